// ===== hdl/tgw_pkg.sv =====
// Shared types, constants and sizes for the text grid writer.
// Used by the sequencer and the top level; depends on nothing else.
package tgw_pkg;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 64;
    localparam int TAB_WIDTH   = 4;
    localparam int MAX_RESULTS = 4;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int CELL_W = 16;

    localparam int TAB_EMITS = (TAB_WIDTH < MAX_RESULTS) ? TAB_WIDTH : MAX_RESULTS;
    localparam int TAB_IDX_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [3:0] COLOR_WHITE = 4'd1;
    localparam logic [3:0] COLOR_BLACK = 4'd0;

    // cell layout: back [15:12], fore [11:8], char [7:0]
    localparam logic [CELL_W-1:0] BLANK_CELL = {COLOR_BLACK, COLOR_WHITE, CH_SPACE};

    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_CURSOR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_FORE = 2'd2,
        CFG_BACK = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COL_W:0] eff_cols;
        logic [ROW_W:0] eff_rows;
        logic [4:0]     fore;
        logic [4:0]     back;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [6:0] col;
        logic [5:0] row;
        logic [7:0] ch;
        logic [3:0] fore;
        logic [3:0] back;
        logic       scrolled;
        logic       last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== hdl/tgw_text_if.sv =====
// Request channel carrying one text byte per transfer.
// Standalone; no package needed.
interface tgw_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== hdl/tgw_cell_if.sv =====
// Result channel carrying one cell write or cursor move per transfer.
// Standalone; no package needed.
interface tgw_cell_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [6:0] cell_col;
    logic [5:0] cell_row;
    logic [7:0] cell_char;
    logic [3:0] cell_fore;
    logic [3:0] cell_back;
    logic       scrolled;
    logic       last_of_run;

    modport source (output valid, output kind, output cell_col, output cell_row,
                    output cell_char, output cell_fore, output cell_back,
                    output scrolled, output last_of_run, input ready);
    modport sink (input valid, input kind, input cell_col, input cell_row,
                  input cell_char, input cell_fore, input cell_back,
                  input scrolled, input last_of_run, output ready);
endinterface

// ===== hdl/tgw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module tgw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tgw_seq.sv =====
// Sequencer of the text grid writer: cursor, clear pass, scroll walk and cell update.
// Depends on tgw_pkg; drives the cell store through a mem_req_t.
module tgw_seq import tgw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_eot,
    input  cfg_t              cfg,
    input  logic              res_free,
    output logic              res_load,
    output res_t              res,
    output mem_req_t          mem,
    input  logic [CELL_W-1:0] mem_rdata
);

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_FIX       = 10'b0000000100,
        S_SCR_RD    = 10'b0000001000,
        S_SCR_WR    = 10'b0000010000,
        S_DISPATCH  = 10'b0000100000,
        S_PUT_START = 10'b0001000000,
        S_PUT_RD    = 10'b0010000000,
        S_PUT_WR    = 10'b0100000000,
        S_NL_EMIT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [COL_W:0]     cursor_col_reg, cursor_col_next;
    logic [ROW_W:0]     cursor_row_reg, cursor_row_next;
    logic               cr_pending_reg, cr_pending_next;
    logic               scrolled_reg, scrolled_next;
    logic [COL_W-1:0]   scan_col_reg, scan_col_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [TAB_IDX_W-1:0] tab_idx_reg, tab_idx_next;
    logic [7:0]         byte_reg, byte_next;
    logic               eot_reg, eot_next;

    logic              is_lf, is_cr, is_tab;
    logic              scan_last_col, scan_last_row;
    logic              emit_ok, emit_last;
    logic [7:0]        put_ch;
    logic [CELL_W-1:0] new_cell;
    logic [ADDR_W-1:0] cursor_addr, scan_addr;

    assign is_lf  = (byte_reg == CH_LF);
    assign is_cr  = (byte_reg == CH_CR);
    assign is_tab = (byte_reg == CH_TAB);
    assign put_ch = is_tab ? CH_SPACE : byte_reg;

    // shared step unit of the walk
    assign scan_last_col = (({1'b0, scan_col_reg} + (COL_W+1)'(1)) == cfg.eff_cols);
    assign scan_last_row = (({1'b0, scan_row_reg} + (ROW_W+1)'(1)) == cfg.eff_rows);
    assign scan_addr     = {scan_row_reg, scan_col_reg};
    assign cursor_addr   = {cursor_row_reg[ROW_W-1:0], cursor_col_reg[COL_W-1:0]};

    assign emit_ok   = !is_tab || ({1'b0, tab_idx_reg} < (TAB_IDX_W+1)'(TAB_EMITS));
    assign emit_last = !is_tab || (tab_idx_reg == TAB_IDX_W'(TAB_EMITS - 1));

    always_comb
    begin
        new_cell = {mem_rdata[CELL_W-1:8], put_ch};
        if (!cfg.fore[4])
        begin
            new_cell[11:8] = cfg.fore[3:0];
        end
        if (!cfg.back[4])
        begin
            new_cell[15:12] = cfg.back[3:0];
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        res.kind     = (state_reg == S_NL_EMIT) ? KIND_CURSOR : KIND_CELL;
        res.col      = 7'(cursor_col_reg);
        res.row      = 6'(cursor_row_reg);
        res.ch       = (state_reg == S_NL_EMIT) ? 8'd0 : new_cell[7:0];
        res.fore     = (state_reg == S_NL_EMIT) ? 4'd0 : new_cell[11:8];
        res.back     = (state_reg == S_NL_EMIT) ? 4'd0 : new_cell[15:12];
        res.scrolled = scrolled_reg;
        res.last     = (state_reg == S_NL_EMIT) ? 1'b1 : emit_last;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        cr_pending_next = cr_pending_reg;
        scrolled_next   = scrolled_reg;
        scan_col_next   = scan_col_reg;
        scan_row_next   = scan_row_reg;
        tab_idx_next    = tab_idx_reg;
        byte_next       = byte_reg;
        eot_next        = eot_reg;
        res_load        = 1'b0;
        mem             = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem.we    = 1'b1;
                mem.waddr = scan_addr;
                mem.wdata = BLANK_CELL;
                {scan_row_next, scan_col_next} = scan_addr + ADDR_W'(1);
                if (scan_addr == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next     = in_byte;
                    eot_next      = in_eot;
                    scrolled_next = 1'b0;
                    tab_idx_next  = '0;
                    ret_next      = S_DISPATCH;
                    state_next    = S_FIX;
                end
            end
            S_FIX:
            begin
                // cursor below the grid: scroll once, then check again
                if (cursor_row_reg >= cfg.eff_rows)
                begin
                    scan_col_next = '0;
                    scan_row_next = '0;
                    scrolled_next = 1'b1;
                    state_next    = S_SCR_RD;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_SCR_RD:
            begin
                if (!scan_last_row)
                begin
                    mem.re    = 1'b1;
                    mem.raddr = {scan_row_reg + ROW_W'(1), scan_col_reg};
                end
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                mem.we    = 1'b1;
                mem.waddr = scan_addr;
                mem.wdata = scan_last_row ? BLANK_CELL : mem_rdata;
                state_next = S_SCR_RD;
                if (scan_last_col)
                begin
                    scan_col_next = '0;
                    if (scan_last_row)
                    begin
                        cursor_row_next = cursor_row_reg - (ROW_W+1)'(1);
                        state_next      = S_FIX;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    scan_col_next = scan_col_reg + COL_W'(1);
                end
            end
            S_DISPATCH:
            begin
                if (is_lf && cr_pending_reg)
                begin
                    // drop LF that follows CR
                    cr_pending_next = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cr_pending_next = is_cr && !eot_reg;
                    if (is_lf || is_cr)
                    begin
                        cursor_col_next = '0;
                        cursor_row_next = cursor_row_reg + (ROW_W+1)'(1);
                        ret_next        = S_NL_EMIT;
                        state_next      = S_FIX;
                    end
                    else
                    begin
                        state_next = S_PUT_START;
                    end
                end
            end
            S_PUT_START:
            begin
                // deferred wrap
                if (cursor_col_reg >= cfg.eff_cols)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = cursor_row_reg + (ROW_W+1)'(1);
                    ret_next        = S_PUT_RD;
                    state_next      = S_FIX;
                end
                else
                begin
                    state_next = S_PUT_RD;
                end
            end
            S_PUT_RD:
            begin
                mem.re     = 1'b1;
                mem.raddr  = cursor_addr;
                state_next = S_PUT_WR;
            end
            S_PUT_WR:
            begin
                if (!emit_ok || res_free)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = cursor_addr;
                    mem.wdata = new_cell;
                    if (emit_ok)
                    begin
                        res_load      = 1'b1;
                        scrolled_next = 1'b0;
                    end
                    cursor_col_next = cursor_col_reg + (COL_W+1)'(1);
                    if (is_tab && (tab_idx_reg != TAB_IDX_W'(TAB_WIDTH - 1)))
                    begin
                        tab_idx_next = tab_idx_reg + TAB_IDX_W'(1);
                        state_next   = S_PUT_START;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_NL_EMIT:
            begin
                if (res_free)
                begin
                    res_load      = 1'b1;
                    scrolled_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ret_reg        <= S_DISPATCH;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            cr_pending_reg <= 1'b0;
            scrolled_reg   <= 1'b0;
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
            tab_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            cr_pending_reg <= cr_pending_next;
            scrolled_reg   <= scrolled_next;
            scan_col_reg   <= scan_col_next;
            scan_row_reg   <= scan_row_next;
            tab_idx_reg    <= tab_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eot_reg  <= eot_next;
    end

endmodule

// ===== hdl/text_grid_writer_with_scroll.sv =====
// Top level of the text grid writer: configuration registers, cell store,
// sequencer and result register. Depends on tgw_pkg, tgw_text_if, tgw_cell_if,
// tgw_ram and tgw_seq.
//
// Text bytes arrive on text_in, one request at a time, and are written into a
// character grid held in one single-port-read, single-port-write RAM of
// MAX_COLS x MAX_ROWS cells (row-major). Every written cell or cursor move
// goes out on cell_out as one request; a tab gives up to four of them, a CR
// or LF one cursor-only request, and an LF right after a CR none. After reset
// the block runs a clearing pass over the whole store, one cell per cycle, and
// holds text_in.ready low until it is done; configuration writes are taken
// during that pass. An ordinary character then goes through accept, scroll
// check, decode, wrap check, RAM read and modify-write before the earliest
// next acceptance; a tab repeats wrap check, RAM read and modify-write for
// each additional space, a CR or LF goes through accept, scroll check, decode,
// a second scroll check and the cursor emit, a dropped LF ends after decode,
// and a wrap to the next line adds one more scroll check. Each cell update is
// a read on the RAM's single read port and a write of the registered data.
// A scroll walks the cols_in_use x rows_in_use cells through that same port,
// a read and a write step per cell, and repeats once per row when the cursor
// sits below a shrunken grid. Results are held in an output register, so the
// next byte is accepted while a result still waits on cell_out.ready; the
// sequencer only stalls when it must hand over a new result and the register
// is still full. Write configuration only while no request is in flight.
module text_grid_writer_with_scroll import tgw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    tgw_text_if.sink              text_in,
    tgw_cell_if.source            cell_out,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;
    logic [4:0] fore_reg;
    logic [4:0] back_reg;
    cfg_t       cfg;

    // result register
    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    logic              res_free;
    logic              res_load;
    res_t              res;
    mem_req_t          mem;
    logic [CELL_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 8'd80;
            rows_reg <= 7'd25;
            fore_reg <= 5'd1;
            back_reg <= 5'd0;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_COLS: cols_reg <= cfg_data;
                CFG_ROWS: rows_reg <= cfg_data[6:0];
                CFG_FORE: fore_reg <= cfg_data[4:0];
                CFG_BACK: back_reg <= cfg_data[4:0];
                default:  cols_reg <= cols_reg;
            endcase
        end
    end

    // saturate the grid size into 1..MAX
    always_comb
    begin
        if (cols_reg == 8'd0)
        begin
            cfg.eff_cols = (COL_W+1)'(1);
        end
        else if (int'(cols_reg) > MAX_COLS)
        begin
            cfg.eff_cols = (COL_W+1)'(MAX_COLS);
        end
        else
        begin
            cfg.eff_cols = (COL_W+1)'(cols_reg);
        end

        if (rows_reg == 7'd0)
        begin
            cfg.eff_rows = (ROW_W+1)'(1);
        end
        else if (int'(rows_reg) > MAX_ROWS)
        begin
            cfg.eff_rows = (ROW_W+1)'(MAX_ROWS);
        end
        else
        begin
            cfg.eff_rows = (ROW_W+1)'(rows_reg);
        end

        cfg.fore = fore_reg;
        cfg.back = back_reg;
    end

    tgw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (mem_rdata)
    );

    tgw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text_in.valid),
        .in_ready  (text_in.ready),
        .in_byte   (text_in.text_byte),
        .in_eot    (text_in.end_of_text),
        .cfg       (cfg),
        .res_free  (res_free),
        .res_load  (res_load),
        .res       (res),
        .mem       (mem),
        .mem_rdata (mem_rdata)
    );

    // hold a result until taken; take a new one in the cycle the old one leaves
    assign res_free = !out_valid_reg || cell_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (cell_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign cell_out.valid       = out_valid_reg;
    assign cell_out.kind        = out_reg.kind;
    assign cell_out.cell_col    = out_reg.col;
    assign cell_out.cell_row    = out_reg.row;
    assign cell_out.cell_char   = out_reg.ch;
    assign cell_out.cell_fore   = out_reg.fore;
    assign cell_out.cell_back   = out_reg.back;
    assign cell_out.scrolled    = out_reg.scrolled;
    assign cell_out.last_of_run = out_reg.last;

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || cell_out.ready))
        else $error("result register overwritten while full");

    // the sequencer is not ready again in the cycle after taking a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (text_in.valid && text_in.ready) |=> !text_in.ready)
        else $error("byte accepted back to back");

    // cursor-only requests carry column zero and no cell contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_out.valid && (cell_out.kind == KIND_CURSOR)) |->
            (cell_out.cell_col == 7'd0 && cell_out.cell_char == 8'd0 &&
             cell_out.cell_fore == 4'd0 && cell_out.cell_back == 4'd0 &&
             cell_out.last_of_run))
        else $error("malformed cursor move");

endmodule
